// ===== rtl/report_frame_crc16_checker_assert.svh =====
// assertion macros for the report frame crc16 checker
`ifndef REPORT_FRAME_CRC16_CHECKER_ASSERT_SVH
`define REPORT_FRAME_CRC16_CHECKER_ASSERT_SVH

// checked while out of reset
`define RFC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define RFC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/rfc_pkg.sv =====
// types and constants for the report frame crc16 checker
package rfc_pkg;

	localparam int BYTE_W     = 8;
	localparam int POS_W      = 6;
	localparam int LEN_W      = 7;
	localparam int CRC_W      = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
	localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;
	localparam logic [LEN_W-1:0] MIN_LEN  = 7'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HEADER_VALUE = 1'b0,
		REG_REPORT_LEN   = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		VERDICT_PENDING  = 2'd0,
		VERDICT_VALID    = 2'd1,
		VERDICT_BAD_HDR  = 2'd2,
		VERDICT_CRC_FAIL = 2'd3
	} verdict_t;

	// reflected crc-16 update by one byte, lsb first
	function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
			input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
		for (int i = 0; i < BYTE_W; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== rtl/rfc_in_if.sv =====
// input word channel: received byte and frame start mark
interface rfc_in_if;
	logic                         valid;
	logic                         ready;
	logic [rfc_pkg::BYTE_W-1:0]   rx_byte;
	logic                         frame_start;

	modport source (output valid, output rx_byte, output frame_start, input ready);
	modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

// ===== rtl/rfc_out_if.sv =====
// output word channel: echoed byte with position and verdict
interface rfc_out_if;
	logic                         valid;
	logic                         ready;
	logic [rfc_pkg::BYTE_W-1:0]   data_byte;
	logic [rfc_pkg::POS_W-1:0]    byte_index;
	logic                         in_report;
	logic                         frame_done;
	logic [1:0]                   verdict;

	modport source (output valid, output data_byte, output byte_index, output in_report,
		output frame_done, output verdict, input ready);
	modport sink   (input valid, input data_byte, input byte_index, input in_report,
		input frame_done, input verdict, output ready);
endinterface

// ===== rtl/report_frame_crc16_checker.sv =====
// Checks fixed-length frames byte by byte: header match and reflected crc-16 over the
// report, echoing every byte with its position; the last byte of a frame carries the
// verdict. One word is accepted every cycle while results are taken at the output; each word
// passes through the input register, then the result register. The byte-wide crc update and
// the position/verdict logic sit between those two registers and set the clock rate.
// An untaken result holds stage 2, and then a full stage 1 too; report_len is saturated to
// 3 .. FRAME_BYTES. Configuration writes belong to idle periods.
`include "report_frame_crc16_checker_assert.svh"

module report_frame_crc16_checker #(
	parameter int FRAME_BYTES = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [rfc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rfc_pkg::CFG_DATA_W-1:0]   cfg_data,
	rfc_in_if.sink                           in_ch,
	rfc_out_if.source                        out_ch
);
	import rfc_pkg::*;

	localparam logic [LEN_W-1:0] FRAME_LEN = LEN_W'(FRAME_BYTES);
	localparam logic [POS_W-1:0] LAST_POS  = POS_W'(FRAME_BYTES - 1);

	// configuration
	logic [BYTE_W-1:0] header_value_q;
	logic [LEN_W-1:0]  report_len_q;

	// stage 1: captured input word
	logic              valid_s1;
	logic [BYTE_W-1:0] rx_byte_s1;
	logic              frame_start_s1;

	// stage 2: result word
	logic              valid_s2;
	logic [BYTE_W-1:0] data_byte_s2;
	logic [POS_W-1:0]  byte_index_s2;
	logic              in_report_s2;
	logic              frame_done_s2;
	verdict_t          verdict_s2;

	// frame state
	logic [CRC_W-1:0]  crc_q;
	logic [POS_W-1:0]  position_q;
	logic              header_ok_q;
	logic [BYTE_W-1:0] crc_low_q;
	verdict_t          verdict_q;

	logic adv2, adv1;

	assign adv2 = valid_s1 && (!valid_s2 || out_ch.ready);
	assign adv1 = in_ch.valid && in_ch.ready;
	assign in_ch.ready = !valid_s1 || adv2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_value_q <= 8'd170;
			report_len_q   <= 7'd45;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_HEADER_VALUE: header_value_q <= cfg_data;
				REG_REPORT_LEN:   report_len_q   <= cfg_data[LEN_W-1:0];
				default:          ;
			endcase
		end
	end

	// combinational work on the stage 1 word
	logic [LEN_W-1:0]  len_eff, len_m1, len_m2, pos_w;
	logic [POS_W-1:0]  pos;
	logic              first, last;
	logic [CRC_W-1:0]  crc_cur, crc_nxt;
	logic              hdr_cur;
	verdict_t          verd_cur, verd_nxt;
	logic [BYTE_W-1:0] crc_low_nxt;

	always_comb begin
		if (report_len_q < MIN_LEN) begin
			len_eff = MIN_LEN;
		end else if (report_len_q > FRAME_LEN) begin
			len_eff = FRAME_LEN;
		end else begin
			len_eff = report_len_q;
		end
		len_m1 = len_eff - 7'd1;
		len_m2 = len_eff - 7'd2;

		pos   = frame_start_s1 ? '0 : position_q;
		pos_w = {1'b0, pos};
		first = (pos == '0);
		last  = (pos >= LAST_POS);

		// a byte at position zero restarts the frame
		crc_cur  = first ? CRC_INIT : crc_q;
		hdr_cur  = first ? (rx_byte_s1 == header_value_q) : header_ok_q;
		verd_cur = first ? VERDICT_PENDING : verdict_q;

		crc_nxt     = crc_cur;
		crc_low_nxt = crc_low_q;
		verd_nxt    = verd_cur;
		if (pos_w < len_m2) begin
			crc_nxt = crc_byte(crc_cur, rx_byte_s1);
		end else if (pos_w == len_m2) begin
			crc_low_nxt = rx_byte_s1;
		end else if (pos_w == len_m1) begin
			if (!hdr_cur) begin
				verd_nxt = VERDICT_BAD_HDR;
			end else if ({rx_byte_s1, crc_low_q} != crc_cur) begin
				verd_nxt = VERDICT_CRC_FAIL;
			end else begin
				verd_nxt = VERDICT_VALID;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			crc_q       <= CRC_INIT;
			position_q  <= '0;
			header_ok_q <= 1'b0;
			crc_low_q   <= '0;
			verdict_q   <= VERDICT_PENDING;
		end else begin
			if (in_ch.ready) begin
				valid_s1 <= in_ch.valid;
			end
			if (adv2) begin
				valid_s2    <= 1'b1;
				crc_q       <= crc_nxt;
				header_ok_q <= hdr_cur;
				crc_low_q   <= crc_low_nxt;
				verdict_q   <= verd_nxt;
				position_q  <= last ? '0 : pos + 6'd1;
			end else if (out_ch.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			rx_byte_s1     <= in_ch.rx_byte;
			frame_start_s1 <= in_ch.frame_start;
		end
		if (adv2) begin
			data_byte_s2  <= rx_byte_s1;
			byte_index_s2 <= pos;
			in_report_s2  <= (pos_w < len_eff);
			frame_done_s2 <= last;
			verdict_s2    <= last ? verd_nxt : VERDICT_PENDING;
		end
	end

	assign out_ch.valid      = valid_s2;
	assign out_ch.data_byte  = data_byte_s2;
	assign out_ch.byte_index = byte_index_s2;
	assign out_ch.in_report  = in_report_s2;
	assign out_ch.frame_done = frame_done_s2;
	assign out_ch.verdict    = verdict_s2;

	// a verdict only shows on the last byte of a frame
	`RFC_ASSERT(a_verdict_on_last, valid_s2 && verdict_s2 != VERDICT_PENDING |-> frame_done_s2, "verdict outside last byte")
	// a frame start word lands at position zero
	`RFC_ASSERT(a_start_pos0, adv2 && frame_start_s1 |=> byte_index_s2 == '0, "frame start not at position zero")
	// position wraps after the last byte
	`RFC_ASSERT(a_wrap, adv2 && last |=> position_q == '0, "position did not wrap")
	// a stalled stage 1 word is not lost or overwritten
	`RFC_ASSERT(a_s1_hold, valid_s1 && !adv2 |=> valid_s1 && $stable(rx_byte_s1), "stage 1 word lost")
	// reset leaves the crc at its initial value and the result stage empty
	`RFC_ASSERT_ALWAYS(a_rst_crc, !arst_n |=> crc_q == CRC_INIT && !valid_s2, "reset state wrong")

endmodule

// ===== tb/report_frame_crc16_checker_test.sv =====
// testbench for the report frame crc16 checker: framed traffic against a scoreboard model
`timescale 1ns / 100ps

module report_frame_crc16_checker_test;
	import rfc_pkg::*;

	localparam int FRAME_BYTES  = 64;
	localparam int RANDOM_WORDS = 720;
	localparam int RANDOM_PHASES = 8;
	localparam int HOLD_AFTER   = 600;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 6;
	localparam longint TIMEOUT_NS = 4_000_000;

	typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

	typedef struct {
		logic [BYTE_W-1:0] data_byte;
		logic [POS_W-1:0]  byte_index;
		logic              in_report;
		logic              frame_done;
		verdict_t          verdict;
	} word_result_t;

	// serial form of the reflected crc-16, one bit per step
	function automatic logic [CRC_W-1:0] crc16_update(logic [CRC_W-1:0] acc,
			logic [BYTE_W-1:0] b);
		logic fb;
		for (int k = 0; k < BYTE_W; k++) begin
			fb = acc[0] ^ b[k];
			acc = acc >> 1;
			if (fb) begin
				acc = acc ^ CRC_POLY;
			end
		end
		return acc;
	endfunction

	function automatic int eff_len(logic [LEN_W-1:0] raw);
		if (raw < 3) begin
			return 3;
		end
		if (raw > FRAME_BYTES) begin
			return FRAME_BYTES;
		end
		return int'(raw);
	endfunction

	class frame_scoreboard;
		word_result_t      expected_q[$];
		logic [BYTE_W-1:0] header_reg;
		logic [LEN_W-1:0]  len_reg;
		logic [CRC_W-1:0]  crc;
		logic [POS_W-1:0]  pos;
		bit                hdr_ok;
		logic [BYTE_W-1:0] crc_lo;
		verdict_t          held_verdict;
		int                errors;
		int                words_checked;
		int                frame_ends[4];

		function new();
			header_reg = 8'd170;
			len_reg = 7'd45;
			crc = CRC_INIT;
			pos = '0;
			hdr_ok = 1'b0;
			crc_lo = '0;
			held_verdict = VERDICT_PENDING;
			errors = 0;
			words_checked = 0;
			frame_ends = '{default: 0};
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
			if (idx == REG_HEADER_VALUE) begin
				header_reg = v;
			end else begin
				len_reg = v[LEN_W-1:0];
			end
		endfunction

		function void note_word(logic [BYTE_W-1:0] b, logic st);
			int len;
			int p;
			logic [CRC_W-1:0] rcv;
			word_result_t r;
			len = eff_len(len_reg);
			if (st) begin
				pos = '0;
			end
			p = int'(pos);
			if (p == 0) begin
				crc = CRC_INIT;
				held_verdict = VERDICT_PENDING;
				hdr_ok = (b == header_reg);
			end
			if (p < len - 2) begin
				crc = crc16_update(crc, b);
			end else if (p == len - 2) begin
				crc_lo = b;
			end else if (p == len - 1) begin
				rcv = {b, crc_lo};
				if (!hdr_ok) begin
					held_verdict = VERDICT_BAD_HDR;
				end else if (rcv != crc) begin
					held_verdict = VERDICT_CRC_FAIL;
				end else begin
					held_verdict = VERDICT_VALID;
				end
			end
			r.data_byte = b;
			r.byte_index = pos;
			r.in_report = (p < len);
			r.frame_done = (p == FRAME_BYTES - 1);
			r.verdict = r.frame_done ? held_verdict : VERDICT_PENDING;
			expected_q.push_back(r);
			pos = r.frame_done ? '0 : pos + 1'b1;
		endfunction

		function void check_word(word_result_t got);
			word_result_t exp_r;
			if (expected_q.size() == 0) begin
				$error("result word with no expected word pending");
				errors++;
				return;
			end
			exp_r = expected_q.pop_front();
			words_checked++;
			if (got.data_byte !== exp_r.data_byte) begin
				$error("data_byte: expected %0h, got %0h", exp_r.data_byte, got.data_byte);
				errors++;
			end
			if (got.byte_index !== exp_r.byte_index) begin
				$error("byte_index: expected %0d, got %0d", exp_r.byte_index, got.byte_index);
				errors++;
			end
			if (got.in_report !== exp_r.in_report) begin
				$error("in_report: expected %0b, got %0b", exp_r.in_report, got.in_report);
				errors++;
			end
			if (got.frame_done !== exp_r.frame_done) begin
				$error("frame_done: expected %0b, got %0b", exp_r.frame_done, got.frame_done);
				errors++;
			end
			if (got.verdict !== exp_r.verdict) begin
				$error("verdict: expected %0d, got %0d", exp_r.verdict, got.verdict);
				errors++;
			end
			if (exp_r.frame_done) begin
				frame_ends[int'(exp_r.verdict)]++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	rfc_in_if  in_ch();
	rfc_out_if out_ch();

	report_frame_crc16_checker #(.FRAME_BYTES(FRAME_BYTES)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	frame_scoreboard   sb = new();
	logic [BYTE_W-1:0] frame_buf [FRAME_BYTES];
	int                words_sent = 0;
	int                settings_seen = 1;
	int                results_taken = 0;
	int                tx_run_left = 0;
	bit                tx_calm = 1'b0;
	int                rx_run_left = 0;
	bit                rx_calm = 1'b0;
	bit                in_sync = 1'b1;

	// gap lengths come in stretches, some of them with no gaps at all
	function automatic int draw_wait(ref int run_left, ref bit calm);
		if (run_left == 0) begin
			run_left = $urandom_range(80, 20);
			calm = ($urandom_range(2, 0) == 0);
		end
		run_left--;
		return calm ? 0 : $urandom_range(11, 0);
	endfunction

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("CHECKS FAILED");
		$finish;
	end

	always @(posedge clk) begin
		word_result_t got;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			sb.note_word(in_ch.rx_byte, in_ch.frame_start);
		end
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.data_byte = out_ch.data_byte;
			got.byte_index = out_ch.byte_index;
			got.in_report = out_ch.in_report;
			got.frame_done = out_ch.frame_done;
			got.verdict = verdict_t'(out_ch.verdict);
			sb.check_word(got);
		end
	end

	// output side: random stalls plus one long hold-off to back the block up
	initial begin
		int stall;
		bit hold_done;
		hold_done = 1'b0;
		out_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			stall = draw_wait(rx_run_left, rx_calm);
			if (!hold_done && results_taken >= HOLD_AFTER) begin
				hold_done = 1'b1;
				stall += HOLD_CYCLES;
			end
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			results_taken++;
		end
	end

	task automatic send_word(logic [BYTE_W-1:0] b, logic st);
		int gap;
		gap = draw_wait(tx_run_left, tx_calm);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.rx_byte <= b;
		in_ch.frame_start <= st;
		do @(posedge clk); while (!in_ch.ready);
		words_sent++;
	endtask

	task automatic send_span(int first, int last_k, bit mark);
		for (int k = first; k <= last_k; k++) begin
			send_word(frame_buf[k], mark && (k == first));
		end
	endtask

	// report with header and trailing crc built for the current settings
	task automatic build_frame(fill_t fill, bit bad_hdr, bit bad_crc);
		int len;
		logic [CRC_W-1:0] c;
		len = eff_len(sb.len_reg);
		for (int k = 0; k < FRAME_BYTES; k++) begin
			case (fill)
				FILL_ZERO: frame_buf[k] = 8'h00;
				FILL_ONES: frame_buf[k] = 8'hFF;
				default:   frame_buf[k] = 8'($urandom_range(255, 0));
			endcase
		end
		frame_buf[0] = bad_hdr ? sb.header_reg ^ 8'($urandom_range(255, 1)) : sb.header_reg;
		c = CRC_INIT;
		for (int k = 0; k < len - 2; k++) begin
			c = crc16_update(c, frame_buf[k]);
		end
		if (bad_crc) begin
			c = c ^ (16'h0001 << $urandom_range(15, 0));
		end
		frame_buf[len-2] = c[7:0];
		frame_buf[len-1] = c[15:8];
	endtask

	// wait until every word is back and the pipeline has emptied
	task automatic settle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		sb.write_reg(idx, v);
	endtask

	task automatic cfg_done();
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_seen++;
	endtask

	task automatic random_phase(int budget);
		int start_words;
		int r;
		int cut;
		fill_t fill;
		start_words = words_sent;
		while (words_sent - start_words < budget) begin
			r = $urandom_range(99, 0);
			if (r < 70) begin
				cut = $urandom_range(9, 0);
				fill = (cut == 0) ? FILL_ZERO : (cut == 1) ? FILL_ONES : FILL_RANDOM;
				build_frame(fill, $urandom_range(99, 0) < 15, $urandom_range(99, 0) < 15);
				send_span(0, FRAME_BYTES - 1, !in_sync || ($urandom_range(3, 0) != 0));
				in_sync = 1'b1;
			end else if (r < 85) begin
				// abandoned frame, the next one has to resync
				build_frame(FILL_RANDOM, 1'b0, 1'b0);
				cut = $urandom_range(FRAME_BYTES - 2, 1);
				send_span(0, cut, !in_sync || $urandom_range(1, 0));
				in_sync = 1'b0;
			end else begin
				cut = $urandom_range(8, 1);
				for (int k = 0; k < cut; k++) begin
					send_word(8'($urandom_range(255, 0)), $urandom_range(3, 0) == 0);
				end
				in_sync = 1'b0;
			end
		end
	endtask

	initial begin
		logic [CFG_DATA_W-1:0] hv;
		logic [CFG_DATA_W-1:0] lv;
		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_HEADER_VALUE;
		cfg_data <= '0;
		in_ch.valid <= 1'b0;
		in_ch.rx_byte <= '0;
		in_ch.frame_start <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: good frames of all zeros and all ones, the second by wrap
		build_frame(FILL_ZERO, 1'b0, 1'b0);
		send_span(0, FRAME_BYTES - 1, 1'b1);
		build_frame(FILL_ONES, 1'b0, 1'b0);
		send_span(0, FRAME_BYTES - 1, 1'b0);
		// bad header wins over a bad crc
		build_frame(FILL_RANDOM, 1'b1, 1'b1);
		send_span(0, FRAME_BYTES - 1, 1'b1);
		build_frame(FILL_RANDOM, 1'b0, 1'b1);
		send_span(0, FRAME_BYTES - 1, 1'b0);
		// frame cut short by a new start
		build_frame(FILL_RANDOM, 1'b0, 1'b0);
		send_span(0, 19, 1'b0);
		// length shrinks past the current position: the report end is skipped
		build_frame(FILL_RANDOM, 1'b0, 1'b0);
		send_span(0, 29, 1'b1);
		settle();
		cfg_write(REG_REPORT_LEN, 8'd10);
		cfg_done();
		send_span(30, FRAME_BYTES - 1, 1'b0);

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			hv = 8'($urandom_range(255, 0));
			case (ph)
				0: begin
					hv = 8'h00;
					lv = 8'd3;
				end
				1: begin
					hv = 8'hFF;
					lv = 8'd64;
				end
				2: lv = 8'd127;
				3: lv = 8'd0;
				4: lv = 8'd2;
				default: lv = 8'($urandom_range(64, 3));
			endcase
			settle();
			cfg_write(REG_HEADER_VALUE, hv);
			cfg_write(REG_REPORT_LEN, lv);
			cfg_done();
			random_phase(RANDOM_WORDS / RANDOM_PHASES);
		end

		settle();
		repeat (8) @(posedge clk);
		$display("covered %0d words under %0d register settings, %0d words checked",
			words_sent, settings_seen, sb.words_checked);
		$display("frame ends: %0d valid, %0d bad header, %0d crc mismatch, %0d pending",
			sb.frame_ends[VERDICT_VALID], sb.frame_ends[VERDICT_BAD_HDR],
			sb.frame_ends[VERDICT_CRC_FAIL], sb.frame_ends[VERDICT_PENDING]);
		if (sb.errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
